>>> sv/rtch_pkg.sv
// ----------------------------------------------------------------------------
// Ray/triangle closest-hit package
// Shared widths, register indexes, datapath commands and status.
// ----------------------------------------------------------------------------
package rtch_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int COORD_W       = 32;
   localparam int DIFF_W        = 33;
   localparam int WIDE_W        = 67;
   localparam int WIDE_LO_W     = 34;
   localparam int MUL_Y_W       = 35;
   localparam int PROD_W        = 68;
   localparam int ACC_W         = 104;
   localparam int QUO_W         = 32;
   localparam int DIST_W        = 31;
   localparam int PT_PROD_W     = 64;
   localparam int CSR_IDX_W     = 3;

   localparam logic [DIST_W-1:0]         DIST_MAX    = '1;
   localparam logic signed [COORD_W-1:0] DIR_Z_RESET = 32'sd65536;
   localparam logic signed [COORD_W-1:0] COORD_MAX   = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] COORD_MIN   = 32'sh8000_0000;

   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_X    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Y    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Z    = 3'd5;

   localparam logic [1:0] COMP_FIRST = 2'd0;
   localparam logic [1:0] COMP_LAST  = 2'd2;
   localparam logic [1:0] PT_DONE    = 2'd3;

   typedef enum logic [2:0] {
      GRP_P, GRP_Q, GRP_R, GRP_DET, GRP_NS, GRP_NT, GRP_NR
   } grp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] v0_x;
      logic signed [COORD_W-1:0] v0_y;
      logic signed [COORD_W-1:0] v0_z;
      logic signed [COORD_W-1:0] v1_x;
      logic signed [COORD_W-1:0] v1_y;
      logic signed [COORD_W-1:0] v1_z;
      logic signed [COORD_W-1:0] v2_x;
      logic signed [COORD_W-1:0] v2_y;
      logic signed [COORD_W-1:0] v2_z;
   } tri_type;

   typedef struct packed {
      logic       load;
      logic       mac_issue;
      grp_type    grp;
      logic [1:0] comp;
      logic       term;
      logic       sign_fix;
      logic       div_start;
      logic       update;
      logic       pt_issue;
      logic [1:0] pt_comp;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic test_pass;
      logic div_done;
   } sts_type;

   function automatic logic [1:0] comp_next(input logic [1:0] c);
      case (c)
         2'd0: return 2'd1;
         2'd1: return 2'd2;
         default: return 2'd0;
      endcase
   endfunction

   function automatic logic [1:0] comp_prev(input logic [1:0] c);
      case (c)
         2'd0: return 2'd2;
         2'd1: return 2'd0;
         default: return 2'd1;
      endcase
   endfunction

endpackage

>>> sv/rtch_if.sv
// ----------------------------------------------------------------------------
// Ray/triangle closest-hit channel interfaces
// Request channel carries one triangle, response channel one mesh result.
// ----------------------------------------------------------------------------
interface rtch_req_if;
   import rtch_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] v0_x;
   logic signed [COORD_W-1:0] v0_y;
   logic signed [COORD_W-1:0] v0_z;
   logic signed [COORD_W-1:0] v1_x;
   logic signed [COORD_W-1:0] v1_y;
   logic signed [COORD_W-1:0] v1_z;
   logic signed [COORD_W-1:0] v2_x;
   logic signed [COORD_W-1:0] v2_y;
   logic signed [COORD_W-1:0] v2_z;
   logic                      last_triangle;

   modport source(output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                  v2_x, v2_y, v2_z, last_triangle, input ready);
   modport sink(input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                v2_x, v2_y, v2_z, last_triangle, output ready);
endinterface

interface rtch_rsp_if;
   import rtch_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      hit;
   logic [DIST_W-1:0]         distance;
   logic signed [COORD_W-1:0] point_x;
   logic signed [COORD_W-1:0] point_y;
   logic signed [COORD_W-1:0] point_z;

   modport source(output valid, hit, distance, point_x, point_y, point_z,
                  input ready);
   modport sink(input valid, hit, distance, point_x, point_y, point_z,
                output ready);
endinterface

>>> sv/rtch_div.sv
// ----------------------------------------------------------------------------
// Ray/triangle closest-hit distance divider
// Restoring divider, one quotient bit per cycle, saturating result.
// ----------------------------------------------------------------------------
module rtch_div #(
   parameter int FRAC_BITS = rtch_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rtch_pkg::ACC_W-1:0]    nr,
   input  logic [rtch_pkg::ACC_W-1:0]    det,
   output logic                          done,
   output logic [rtch_pkg::DIST_W-1:0]   quo
);
   import rtch_pkg::*;

   localparam int SH_W  = (FRAC_BITS > QUO_W - 1) ? FRAC_BITS : QUO_W - 1;
   localparam int DIV_W = ACC_W + SH_W;
   localparam int CNT_W = $clog2(QUO_W);

   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] den_ff, den_in;
   logic [QUO_W-1:0] q_ff, q_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DIV_W:0]   diff;

   always_comb begin
      diff    = {1'b0, rem_ff} - {1'b0, den_ff};
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = DIV_W'(nr) << FRAC_BITS;
         den_in  = DIV_W'(det) << (QUO_W - 1);
         q_in    = '0;
         cnt_in  = CNT_W'(QUO_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DIV_W]) begin
            rem_in = diff[DIV_W-1:0];
            q_in   = {q_ff[QUO_W-2:0], 1'b1};
         end else begin
            q_in   = {q_ff[QUO_W-2:0], 1'b0};
         end
         den_in = den_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign quo  = q_ff[QUO_W-1] ? DIST_MAX : q_ff[DIST_W-1:0];

endmodule

>>> sv/rtch_ctrl.sv
// ----------------------------------------------------------------------------
// Ray/triangle closest-hit controller
// Sequences the product steps, the hit test, the divide and the result.
// ----------------------------------------------------------------------------
module rtch_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_last,
   output logic              req_ready,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   input  rtch_pkg::sts_type sts,
   output rtch_pkg::cmd_type cmd
);
   import rtch_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_MAC, S_DRAIN, S_SIGN, S_TEST, S_DIV, S_POINT, S_EMIT
   } state_type;

   state_type  state_ff, state_in;
   grp_type    grp_ff, grp_in;
   logic [1:0] comp_ff, comp_in;
   logic       term_ff, term_in;
   logic [1:0] pt_ff, pt_in;
   logic       last_ff, last_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      cmd.grp      = grp_ff;
      cmd.comp     = comp_ff;
      cmd.term     = term_ff;
      cmd.pt_comp  = pt_ff;
      state_in     = state_ff;
      grp_in       = grp_ff;
      comp_in      = comp_ff;
      term_in      = term_ff;
      pt_in        = pt_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               last_in  = req_last;
               grp_in   = GRP_P;
               comp_in  = COMP_FIRST;
               term_in  = 1'b0;
               state_in = S_MAC;
            end
         end
         S_MAC: begin
            cmd.mac_issue = 1'b1;
            term_in       = !term_ff;
            if (term_ff) begin
               if (comp_ff == COMP_LAST) begin
                  comp_in = COMP_FIRST;
                  if (grp_ff == GRP_NR) begin
                     state_in = S_DRAIN;
                  end else begin
                     grp_in = grp_type'(grp_ff + 3'd1);
                  end
               end else begin
                  comp_in = comp_ff + 2'd1;
               end
            end
         end
         S_DRAIN: begin
            state_in = S_SIGN;
         end
         S_SIGN: begin
            cmd.sign_fix = 1'b1;
            state_in     = S_TEST;
         end
         S_TEST: begin
            pt_in = '0;
            if (sts.test_pass) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else if (last_ff) begin
               state_in = S_POINT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               cmd.update = 1'b1;
               state_in   = last_ff ? S_POINT : S_IDLE;
            end
         end
         S_POINT: begin
            cmd.pt_issue = (pt_ff != PT_DONE);
            pt_in        = pt_ff + 2'd1;
            if (pt_ff == PT_DONE) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         grp_ff       <= GRP_P;
         comp_ff      <= COMP_FIRST;
         term_ff      <= 1'b0;
         pt_ff        <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         grp_ff       <= grp_in;
         comp_ff      <= comp_in;
         term_ff      <= term_in;
         pt_ff        <= pt_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> sv/rtch_datapath.sv
// ----------------------------------------------------------------------------
// Ray/triangle closest-hit datapath
// Ray registers, edge vectors, shared multiply-accumulate, test and hit point.
// ----------------------------------------------------------------------------
module rtch_datapath #(
   parameter int FRAC_BITS = rtch_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rtch_pkg::cmd_type                   cmd,
   output rtch_pkg::sts_type                   sts,
   input  rtch_pkg::tri_type                   tri_in,
   input  logic                                csr_wr_en,
   input  logic [rtch_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rtch_pkg::COORD_W-1:0]        csr_wdata,
   output logic                                rsp_hit,
   output logic [rtch_pkg::DIST_W-1:0]         rsp_distance,
   output logic signed [rtch_pkg::COORD_W-1:0] rsp_point_x,
   output logic signed [rtch_pkg::COORD_W-1:0] rsp_point_y,
   output logic signed [rtch_pkg::COORD_W-1:0] rsp_point_z
);
   import rtch_pkg::*;

   logic signed [COORD_W-1:0] org_ff[3];
   logic signed [COORD_W-1:0] dir_ff[3];
   logic signed [COORD_W-1:0] vt0[3], vt1[3], vt2[3];
   logic signed [DIFF_W-1:0]  u_ff[3], v_ff[3], w_ff[3], n_ff[3];
   logic signed [WIDE_W-1:0]  p_ff[3], q_ff[3], r_ff[3];
   logic signed [ACC_W-1:0]   acc_ff, det_ff, ns_ff, nt_ff, nr_ff;

   logic [1:0]                c_nx, c_pv, ia, ib;
   logic                      is_cross;
   logic signed [DIFF_W-1:0]  mx;
   logic signed [MUL_Y_W-1:0] my;
   logic signed [WIDE_W-1:0]  wide;

   logic                      mac_v_ff, mac_clr_ff, mac_sub_ff, mac_sh_ff, mac_wr_ff;
   grp_type                   mac_grp_ff;
   logic [1:0]                mac_comp_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   add_v, base_v, acc_next;

   logic signed [ACC_W+1:0]   slack;

   logic                      div_done;
   logic [DIST_W-1:0]         div_quo;

   logic                      any_ff;
   logic [DIST_W-1:0]         best_ff;

   logic                      pt_v_ff;
   logic [1:0]                pt_c_ff;
   logic signed [PT_PROD_W-1:0] pt_prod_ff, pt_sh, pt_sum;
   logic signed [COORD_W-1:0] pt_sat;
   logic signed [COORD_W-1:0] pnt_ff[3];

   logic                      hit_ff;
   logic [DIST_W-1:0]         dist_ff;
   logic signed [COORD_W-1:0] out_ff[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         org_ff[0] <= '0;
         org_ff[1] <= '0;
         org_ff[2] <= '0;
         dir_ff[0] <= '0;
         dir_ff[1] <= '0;
         dir_ff[2] <= DIR_Z_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ORIGIN_X: org_ff[0] <= $signed(csr_wdata);
            CSR_ORIGIN_Y: org_ff[1] <= $signed(csr_wdata);
            CSR_ORIGIN_Z: org_ff[2] <= $signed(csr_wdata);
            CSR_DIR_X:    dir_ff[0] <= $signed(csr_wdata);
            CSR_DIR_Y:    dir_ff[1] <= $signed(csr_wdata);
            CSR_DIR_Z:    dir_ff[2] <= $signed(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      vt0[0] = tri_in.v0_x;
      vt0[1] = tri_in.v0_y;
      vt0[2] = tri_in.v0_z;
      vt1[0] = tri_in.v1_x;
      vt1[1] = tri_in.v1_y;
      vt1[2] = tri_in.v1_z;
      vt2[0] = tri_in.v2_x;
      vt2[1] = tri_in.v2_y;
      vt2[2] = tri_in.v2_z;
   end

   // Operand selection for one product step.
   always_comb begin
      c_nx     = comp_next(cmd.comp);
      c_pv     = comp_prev(cmd.comp);
      ia       = cmd.term ? c_pv : c_nx;
      ib       = cmd.term ? c_nx : c_pv;
      is_cross = 1'b0;
      mx       = '0;
      my       = '0;
      wide     = '0;
      case (cmd.grp)
         GRP_P: begin
            is_cross = 1'b1;
            mx       = u_ff[ia];
            my       = MUL_Y_W'(n_ff[ib]);
         end
         GRP_Q: begin
            is_cross = 1'b1;
            mx       = w_ff[ia];
            my       = MUL_Y_W'(n_ff[ib]);
         end
         GRP_R: begin
            is_cross = 1'b1;
            mx       = u_ff[ia];
            my       = MUL_Y_W'(w_ff[ib]);
         end
         GRP_DET: begin
            mx   = v_ff[cmd.comp];
            wide = p_ff[cmd.comp];
         end
         GRP_NS: begin
            mx   = w_ff[cmd.comp];
            wide = p_ff[cmd.comp];
         end
         GRP_NT: begin
            mx   = v_ff[cmd.comp];
            wide = q_ff[cmd.comp];
         end
         GRP_NR: begin
            mx   = v_ff[cmd.comp];
            wide = r_ff[cmd.comp];
         end
         default: begin
         end
      endcase
      if (!is_cross) begin
         my = cmd.term ? MUL_Y_W'($signed(wide[WIDE_W-1:WIDE_LO_W]))
                       : $signed({1'b0, wide[WIDE_LO_W-1:0]});
      end
   end

   always_comb begin
      add_v    = ACC_W'(prod_ff);
      if (mac_sh_ff) begin
         add_v = add_v <<< WIDE_LO_W;
      end
      base_v   = mac_clr_ff ? '0 : acc_ff;
      acc_next = mac_sub_ff ? (base_v - add_v) : (base_v + add_v);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mac_v_ff <= 1'b0;
         pt_v_ff  <= 1'b0;
      end else begin
         mac_v_ff <= cmd.mac_issue;
         pt_v_ff  <= cmd.pt_issue;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= mx * my;
      mac_clr_ff  <= is_cross ? !cmd.term : (cmd.comp == COMP_FIRST && !cmd.term);
      mac_wr_ff   <= is_cross ? cmd.term : (cmd.comp == COMP_LAST && cmd.term);
      mac_sub_ff  <= is_cross && cmd.term;
      mac_sh_ff   <= !is_cross && cmd.term;
      mac_grp_ff  <= cmd.grp;
      mac_comp_ff <= cmd.comp;
      if (cmd.load) begin
         for (int k = 0; k < 3; k++) begin
            u_ff[k] <= DIFF_W'(vt1[k]) - DIFF_W'(vt0[k]);
            v_ff[k] <= DIFF_W'(vt2[k]) - DIFF_W'(vt0[k]);
            w_ff[k] <= DIFF_W'(org_ff[k]) - DIFF_W'(vt0[k]);
            n_ff[k] <= -DIFF_W'(dir_ff[k]);
         end
      end
      if (mac_v_ff) begin
         acc_ff <= acc_next;
         if (mac_wr_ff) begin
            case (mac_grp_ff)
               GRP_P:   p_ff[mac_comp_ff] <= WIDE_W'(acc_next);
               GRP_Q:   q_ff[mac_comp_ff] <= WIDE_W'(acc_next);
               GRP_R:   r_ff[mac_comp_ff] <= WIDE_W'(acc_next);
               GRP_DET: det_ff <= acc_next;
               GRP_NS:  ns_ff  <= acc_next;
               GRP_NT:  nt_ff  <= acc_next;
               GRP_NR:  nr_ff  <= acc_next;
               default: begin
               end
            endcase
         end
      end else if (cmd.sign_fix && det_ff[ACC_W-1]) begin
         det_ff <= -det_ff;
         ns_ff  <= -ns_ff;
         nt_ff  <= -nt_ff;
         nr_ff  <= -nr_ff;
      end
   end

   assign slack = (ACC_W+2)'(det_ff) - (ACC_W+2)'(ns_ff) - (ACC_W+2)'(nt_ff);

   assign sts.test_pass = (det_ff != '0) && !ns_ff[ACC_W-1] && !nt_ff[ACC_W-1] &&
                          !nr_ff[ACC_W-1] && !slack[ACC_W+1];
   assign sts.div_done  = div_done;

   rtch_div #(
      .FRAC_BITS(FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .nr    (nr_ff),
      .det   (det_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         any_ff  <= 1'b0;
         best_ff <= '0;
      end else if (cmd.rsp_load) begin
         any_ff  <= 1'b0;
         best_ff <= '0;
      end else if (cmd.update) begin
         if (!any_ff || (div_quo < best_ff)) begin
            best_ff <= div_quo;
         end
         any_ff <= 1'b1;
      end
   end

   // Hit point: origin plus direction times distance, floored and saturated.
   always_comb begin
      pt_sh  = pt_prod_ff >>> FRAC_BITS;
      pt_sum = PT_PROD_W'(org_ff[pt_c_ff]) + pt_sh;
      if (pt_sum > PT_PROD_W'(COORD_MAX)) begin
         pt_sat = COORD_MAX;
      end else if (pt_sum < PT_PROD_W'(COORD_MIN)) begin
         pt_sat = COORD_MIN;
      end else begin
         pt_sat = COORD_W'(pt_sum);
      end
   end

   always_ff @(posedge clock) begin
      pt_prod_ff <= dir_ff[cmd.pt_comp] * $signed({1'b0, best_ff});
      pt_c_ff    <= cmd.pt_comp;
      if (pt_v_ff) begin
         pnt_ff[pt_c_ff] <= pt_sat;
      end
      if (cmd.rsp_load) begin
         hit_ff  <= any_ff;
         dist_ff <= any_ff ? best_ff : '0;
         for (int k = 0; k < 3; k++) begin
            out_ff[k] <= any_ff ? pnt_ff[k] : '0;
         end
      end
   end

   assign rsp_hit      = hit_ff;
   assign rsp_distance = dist_ff;
   assign rsp_point_x  = out_ff[0];
   assign rsp_point_y  = out_ff[1];
   assign rsp_point_z  = out_ff[2];

endmodule

>>> sv/ray_triangle_closest_hit_unit.sv
// ----------------------------------------------------------------------------
// Ray/triangle closest-hit unit
// Finds the nearest triangle of a mesh hit by a configured ray.
// ----------------------------------------------------------------------------
// The ray origin and direction are written through the csr port; the user
// must write them only while the unit is idle, which the unit does not
// enforce. Each request carries one triangle and a flag that marks the
// last triangle of a mesh. Only the last triangle produces a response: the
// hit flag, the closest distance and the world hit point.
// A triangle that misses takes a load step, product steps on the shared
// multiply-accumulate unit, then drain, sign and test states. A hit adds
// the restoring divider, one quotient bit a cycle, and the last triangle
// adds the hit point steps. The unit takes one request at a time.
// Reset clears the ray to origin zero and direction +z, and clears the
// stored closest hit. A response waits in an output register while the
// receiver stalls; the unit keeps taking requests and only holds a new
// response until the previous one is taken.
// ----------------------------------------------------------------------------
module ray_triangle_closest_hit_unit #(
   parameter int FRAC_BITS = rtch_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   rtch_req_if.sink                       req_ch,
   rtch_rsp_if.source                     rsp_ch,
   input  logic                           csr_wr_en,
   input  logic [rtch_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rtch_pkg::COORD_W-1:0]   csr_wdata
);
   import rtch_pkg::*;

   cmd_type cmd;
   sts_type sts;
   tri_type tri_v;

   assign tri_v.v0_x = req_ch.v0_x;
   assign tri_v.v0_y = req_ch.v0_y;
   assign tri_v.v0_z = req_ch.v0_z;
   assign tri_v.v1_x = req_ch.v1_x;
   assign tri_v.v1_y = req_ch.v1_y;
   assign tri_v.v1_z = req_ch.v1_z;
   assign tri_v.v2_x = req_ch.v2_x;
   assign tri_v.v2_y = req_ch.v2_y;
   assign tri_v.v2_z = req_ch.v2_z;

   rtch_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_last  (req_ch.last_triangle),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   rtch_datapath #(
      .FRAC_BITS(FRAC_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .tri_in       (tri_v),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_hit      (rsp_ch.hit),
      .rsp_distance (rsp_ch.distance),
      .rsp_point_x  (rsp_ch.point_x),
      .rsp_point_y  (rsp_ch.point_y),
      .rsp_point_z  (rsp_ch.point_z)
   );

`ifndef NO_ASSERTIONS
   a_div_latency : assert property (@(posedge clock) disable iff (reset)
      sts.div_done |-> $past(cmd.div_start, 33))
      else $error("divider finished without a start 33 cycles earlier");

   a_rsp_no_hit_zero : assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_ch.valid && (rsp_ch.hit || (rsp_ch.distance == '0)))
      else $error("response without a hit carries a distance");

   a_rsp_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |-> !cmd.rsp_load)
      else $error("stalled response overwritten");
`endif

endmodule
